FILE: rtl/core/alist_pkg.sv
// Shared codes, field widths and controller/datapath interface types for the array list.
`timescale 1ns / 1ps

package alist_pkg;

    // Transfer field widths
    localparam int OP_W    = 2;
    localparam int POS_W   = 6;
    localparam int VAL_W   = 32;
    localparam int STAT_W  = 3;
    localparam int FPOS_W  = 6;
    localparam int CNT_W   = 7;
    localparam int IN_W    = OP_W + POS_W + VAL_W;
    localparam int OUT_W   = STAT_W + VAL_W + FPOS_W + CNT_W;

    // Operation codes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_LOCATE = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [STAT_W-1:0] ST_BADPOS   = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic              cap;         // latch the input transfer
        logic              ins_init;    // pointer to the end of the list
        logic              del_init;    // read the victim, pointer past it
        logic              loc_init;    // pointer to the head of the list
        logic              mv_up;       // move entry ptr-1 to ptr
        logic              mv_dn;       // move entry ptr to ptr-1
        logic              lk;          // read entry ptr for comparison
        logic              take;        // keep the value read as removed value
        logic              put;         // write the new value, count up
        logic              dec;         // count down
        logic              res_we;      // record the result
        logic [STAT_W-1:0] res_status;
        logic              res_found;
        logic              res_removed;
        logic              out_load;    // move result to the output register
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            full;
        logic            empty;
        logic            ins_bad;
        logic            del_bad;
        logic            ins_more;
        logic            scan_more;
        logic            hit;
    } t_dp_stat;

endpackage

FILE: rtl/core/alist_dp.sv
// Datapath of the array list: entry memory, count, pointer, compare and result registers.
`timescale 1ns / 1ps

module alist_dp import alist_pkg::*; #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_dp_cmd          i_cmd,
    output t_dp_stat         o_stat,
    input  logic [IN_W-1:0]  i_in_data,
    output logic [OUT_W-1:0] o_out_data
);

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int XW = CW + POS_W;

    // Latched request
    logic [OP_W-1:0]   r_op;
    logic [POS_W-1:0]  r_pos;
    logic [VAL_W-1:0]  r_val;

    logic [CW-1:0]     r_count;
    logic [CW-1:0]     r_ptr;
    logic [VAL_W-1:0]  mem [MAX_ENTRIES];
    logic [VAL_W-1:0]  r_rdata;
    logic [AW-1:0]     r_wa;
    logic              r_pend;
    logic [AW-1:0]     r_ca;
    logic              r_cmpv;
    logic [VAL_W-1:0]  r_taken;
    logic [STAT_W-1:0] r_status;
    logic [FPOS_W-1:0] r_found;
    logic [VAL_W-1:0]  r_removed;
    logic [OUT_W-1:0]  r_out;

    logic [XW-1:0]        w_pos_x;
    logic [XW-1:0]        w_cnt_x;
    logic [XW-1:0]        w_ptr_x;
    logic [XW-1:0]        w_pos_p1;
    logic [AW+POS_W-1:0]  w_pos_wide;
    logic [AW-1:0]        w_pos_addr;
    logic [CW-1:0]        w_ptr_m1;
    logic [CW-1:0]        w_ptr_p1;
    logic [AW+FPOS_W-1:0] w_ca_wide;
    logic [CW+CNT_W-1:0]  w_cnt_wide;
    logic [AW-1:0]        w_ra;
    logic                 w_we;
    logic [AW-1:0]        w_wa;
    logic [VAL_W-1:0]     w_wd;

    // Widen operands so compares work for any list depth
    assign w_pos_x    = {{CW{1'b0}}, r_pos};
    assign w_cnt_x    = {{POS_W{1'b0}}, r_count};
    assign w_ptr_x    = {{POS_W{1'b0}}, r_ptr};
    assign w_pos_p1   = w_pos_x + XW'(1);
    assign w_pos_wide = {{AW{1'b0}}, r_pos};
    assign w_pos_addr = w_pos_wide[AW-1:0];
    assign w_ptr_m1   = r_ptr - CW'(1);
    assign w_ptr_p1   = r_ptr + CW'(1);
    assign w_ca_wide  = {{FPOS_W{1'b0}}, r_ca};
    assign w_cnt_wide = {{CNT_W{1'b0}}, r_count};

    // Status towards the controller
    assign o_stat.op        = r_op;
    assign o_stat.full      = (r_count == CW'(MAX_ENTRIES));
    assign o_stat.empty     = (r_count == '0);
    assign o_stat.ins_bad   = (w_pos_x > w_cnt_x);
    assign o_stat.del_bad   = (w_pos_x >= w_cnt_x);
    assign o_stat.ins_more  = (w_ptr_x > w_pos_x);
    assign o_stat.scan_more = (r_ptr < r_count);
    assign o_stat.hit       = r_cmpv && (r_rdata == r_val);

    // Select the read address
    always_comb begin
        priority if (i_cmd.del_init) begin
            w_ra = w_pos_addr;
        end else if (i_cmd.mv_up) begin
            w_ra = w_ptr_m1[AW-1:0];
        end else begin
            w_ra = r_ptr[AW-1:0];
        end
    end

    // Pending move write has the port; otherwise the new value goes in
    assign w_we = r_pend || i_cmd.put;
    assign w_wa = r_pend ? r_wa : w_pos_addr;
    assign w_wd = r_pend ? r_rdata : r_val;

    // Entry memory, one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_wa] <= w_wd;
        end
        r_rdata <= mem[w_ra];
    end

    // Latch the request and walk the pointer
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_op  <= i_in_data[OP_W-1:0];
            r_pos <= i_in_data[OP_W+POS_W-1:OP_W];
            r_val <= i_in_data[IN_W-1:OP_W+POS_W];
        end
        priority if (i_cmd.ins_init) begin
            r_ptr <= r_count;
        end else if (i_cmd.del_init) begin
            r_ptr <= w_pos_p1[CW-1:0];
        end else if (i_cmd.loc_init) begin
            r_ptr <= '0;
        end else if (i_cmd.mv_up) begin
            r_ptr <= w_ptr_m1;
        end else if (i_cmd.mv_dn || i_cmd.lk) begin
            r_ptr <= w_ptr_p1;
        end
        // Remember where the data in flight belongs
        if (i_cmd.mv_up) begin
            r_wa <= r_ptr[AW-1:0];
        end else if (i_cmd.mv_dn) begin
            r_wa <= w_ptr_m1[AW-1:0];
        end
        if (i_cmd.lk) begin
            r_ca <= r_ptr[AW-1:0];
        end
        if (i_cmd.take) begin
            r_taken <= r_rdata;
        end
    end

    // Control flags and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_pend  <= 1'b0;
            r_cmpv  <= 1'b0;
        end else begin
            r_pend <= i_cmd.mv_up || i_cmd.mv_dn;
            r_cmpv <= i_cmd.lk;
            if (i_cmd.put) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.dec) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // Record the result, then hand it to the output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_we) begin
            r_status  <= i_cmd.res_status;
            r_found   <= i_cmd.res_found ? w_ca_wide[FPOS_W-1:0] : '0;
            r_removed <= i_cmd.res_removed ? r_taken : '0;
        end
        if (i_cmd.out_load) begin
            r_out <= {w_cnt_wide[CNT_W-1:0], r_found, r_removed, r_status};
        end
    end

    assign o_out_data = r_out;

endmodule

FILE: rtl/core/alist_ctrl.sv
// Controller of the array list: sequences dispatch, shifts, scan and result hand-off.
`timescale 1ns / 1ps

module alist_ctrl import alist_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s_tvalid,
    output logic     o_s_tready,
    output logic     o_m_tvalid,
    input  logic     i_m_tready,
    output t_dp_cmd  o_cmd,
    input  t_dp_stat i_stat
);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_DISP      = 3'd1;
    localparam logic [2:0] S_INS_SHIFT = 3'd2;
    localparam logic [2:0] S_INS_PUT   = 3'd3;
    localparam logic [2:0] S_DEL_TAKE  = 3'd4;
    localparam logic [2:0] S_DEL_SHIFT = 3'd5;
    localparam logic [2:0] S_LOC_SCAN  = 3'd6;
    localparam logic [2:0] S_FIN       = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       w_out_free;

    // Take no transfer while reset is held
    assign o_s_tready = (r_state == S_IDLE) && i_rst_n;
    assign o_m_tvalid = r_out_valid;
    assign w_out_free = !r_out_valid || i_m_tready;

    // Next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = S_DISP;
                end
            end
            S_DISP: begin
                n_state        = S_FIN;
                o_cmd.res_we   = 1'b1;
                o_cmd.res_status = ST_OK;
                unique case (i_stat.op)
                    OP_INSERT: begin
                        if (i_stat.full) begin
                            o_cmd.res_status = ST_FULL;
                        end else if (i_stat.ins_bad) begin
                            o_cmd.res_status = ST_BADPOS;
                        end else begin
                            o_cmd.res_we   = 1'b0;
                            o_cmd.ins_init = 1'b1;
                            n_state        = S_INS_SHIFT;
                        end
                    end
                    OP_DELETE: begin
                        if (i_stat.empty) begin
                            o_cmd.res_status = ST_EMPTY;
                        end else if (i_stat.del_bad) begin
                            o_cmd.res_status = ST_BADPOS;
                        end else begin
                            o_cmd.res_we   = 1'b0;
                            o_cmd.del_init = 1'b1;
                            n_state        = S_DEL_TAKE;
                        end
                    end
                    OP_LOCATE: begin
                        o_cmd.res_we   = 1'b0;
                        o_cmd.loc_init = 1'b1;
                        n_state        = S_LOC_SCAN;
                    end
                    OP_NONE: begin
                        o_cmd.res_status = ST_OK;
                    end
                endcase
            end
            S_INS_SHIFT: begin
                // Move entries up one at a time, last one first
                if (i_stat.ins_more) begin
                    o_cmd.mv_up = 1'b1;
                end else begin
                    n_state = S_INS_PUT;
                end
            end
            S_INS_PUT: begin
                o_cmd.put        = 1'b1;
                o_cmd.res_we     = 1'b1;
                o_cmd.res_status = ST_OK;
                n_state          = S_FIN;
            end
            S_DEL_TAKE: begin
                o_cmd.take = 1'b1;
                n_state    = S_DEL_SHIFT;
            end
            S_DEL_SHIFT: begin
                // Close the gap, nearest entry first
                if (i_stat.scan_more) begin
                    o_cmd.mv_dn = 1'b1;
                end else begin
                    o_cmd.dec         = 1'b1;
                    o_cmd.res_we      = 1'b1;
                    o_cmd.res_status  = ST_OK;
                    o_cmd.res_removed = 1'b1;
                    n_state           = S_FIN;
                end
            end
            S_LOC_SCAN: begin
                // Compare the previous read while issuing the next
                if (i_stat.hit) begin
                    o_cmd.res_we     = 1'b1;
                    o_cmd.res_status = ST_OK;
                    o_cmd.res_found  = 1'b1;
                    n_state          = S_FIN;
                end else if (i_stat.scan_more) begin
                    o_cmd.lk = 1'b1;
                end else begin
                    o_cmd.res_we     = 1'b1;
                    o_cmd.res_status = ST_NOTFOUND;
                    n_state          = S_FIN;
                end
            end
            S_FIN: begin
                // Hold until the output register is free
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
        endcase
    end

    // Output valid: set on load, drop on transfer
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

FILE: rtl/core/array_list_insert_delete_locate_top.sv
// Top level of the array list: ordered list with insert, delete and locate.
//
//  Channel  Direction  Ports                            Payload
//  s        in         i_s_tvalid o_s_tready i_s_tdata  operation, position, item_value
//  m        out        o_m_tvalid i_m_tready o_m_tdata  status, removed_value,
//                                                       found_position, entry_count
//
// One request at a time. Insert and delete take longer the more entries
// lie above the position, locate the more entries it scans, and a stall
// of the output adds to the time; the entry memory, with one write and one
// read port, moves or reads one entry a cycle. Reset (synchronous, active
// low) empties the list; entries need no clearing since only held ones
// are read.
// The result waits in an output register; a new request is taken once it
// has been loaded.
`timescale 1ns / 1ps

module array_list_insert_delete_locate_top import alist_pkg::*; #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    // [1:0] operation, [7:2] position, [39:8] item_value
    input  logic [IN_W-1:0]  i_s_tdata,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    // [2:0] status, [34:3] removed_value, [40:35] found_position, [47:41] entry_count
    output logic [OUT_W-1:0] o_m_tdata
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // Sequencer
    alist_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (w_cmd),
        .i_stat     (w_stat)
    );

    // Storage and arithmetic
    alist_dp #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_in_data  (i_s_tdata),
        .o_out_data (o_m_tdata)
    );

endmodule
